FILE: design/hlfr_pkg.sv
// ----------------------------------------------------------------------------
// hlfr_pkg: shared types and constants of the header/length frame receiver
// Holds the configuration register indexes, the position codes of the
// frame parser and the record of one result.
// ----------------------------------------------------------------------------
`default_nettype none

package hlfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_FIRST     = 3'd0,
    REG_HEADER_SECOND    = 3'd1,
    REG_ID_RETURN_OK     = 3'd2,
    REG_ID_RETURN_NG     = 3'd3,
    REG_ID_RESEND_RESULT = 3'd4,
    REG_ID_DATA_ACK      = 3'd5,
    REG_ID_DATA_NOACK    = 3'd6
  } cfg_reg_t;

  // Frame positions with a meaning of their own.
  localparam logic [ByteW-1:0] POS_HUNT    = 8'd0;
  localparam logic [ByteW-1:0] POS_HEADER2 = 8'd1;
  localparam logic [ByteW-1:0] POS_LENGTH  = 8'd2;
  localparam logic [ByteW-1:0] POS_MSG_ID  = 8'd3;

  // Shortest legal frame: two header bytes, length and message id.
  localparam logic [ByteW-1:0] MIN_FRAME_LEN = 8'd4;

  // Register file contents seen by the parser.
  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] id_return_ok;
    logic [ByteW-1:0] id_return_ng;
    logic [ByteW-1:0] id_resend_result;
    logic [ByteW-1:0] id_data_ack;
    logic [ByteW-1:0] id_data_noack;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic [ByteW-1:0] byte_pos;
    logic             frame_last;
    logic             length_error;
    logic [ByteW-1:0] msg_id;
    logic             is_cmd_result;
    logic             is_data_msg;
  } result_t;

endpackage

`default_nettype wire

FILE: design/hlfr_parser.sv
// ----------------------------------------------------------------------------
// hlfr_parser: frame parser of the header/length frame receiver
// Tracks the position in the current frame, checks the two header bytes,
// takes the length and the message id and builds the result for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfr_parser
  import hlfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] rx_byte,
  output logic                  res_valid,
  output result_t               res
);

  logic [ByteW-1:0] pos_r, pos_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] id_r, id_nxt;
  logic [ByteW-1:0] cur_id;
  logic [ByteW:0]   pos_plus_one;
  logic             is_last;

  // Position and frame registers advance once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      len_r <= '0;
      id_r  <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      id_r  <= id_nxt;
    end
  end

  // The message id byte is both captured and, for a four byte frame,
  // classified in the same cycle.
  assign cur_id       = (pos_r == POS_MSG_ID) ? rx_byte : id_r;
  assign pos_plus_one = {1'b0, pos_r} + {{ByteW{1'b0}}, 1'b1};
  assign is_last      = pos_plus_one >= {1'b0, len_r};

  // Next state and result for the byte at the input.
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    id_nxt    = cur_id;
    res_valid = 1'b0;
    res       = '0;
    res.frame_byte = rx_byte;
    res.byte_pos   = pos_r;
    unique case (pos_r)
      POS_HUNT: begin
        if (rx_byte == cfg.header_first) begin
          pos_nxt   = POS_HEADER2;
          res_valid = 1'b1;
        end
      end
      POS_HEADER2: begin
        if (rx_byte == cfg.header_second) begin
          pos_nxt   = POS_LENGTH;
          res_valid = 1'b1;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end
      POS_LENGTH: begin
        res_valid = 1'b1;
        if (rx_byte < MIN_FRAME_LEN) begin
          pos_nxt          = POS_HUNT;
          res.length_error = 1'b1;
        end else begin
          pos_nxt = POS_MSG_ID;
          len_nxt = rx_byte;
        end
      end
      default: begin
        res_valid = 1'b1;
        if (is_last) begin
          pos_nxt           = POS_HUNT;
          res.frame_last    = 1'b1;
          res.msg_id        = cur_id;
          res.is_cmd_result = (cur_id == cfg.id_return_ok) ||
                              (cur_id == cfg.id_return_ng) ||
                              (cur_id == cfg.id_resend_result);
          res.is_data_msg   = (cur_id == cfg.id_data_ack) ||
                              (cur_id == cfg.id_data_noack);
        end else begin
          pos_nxt = pos_plus_one[ByteW-1:0];
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/hlfr_out_buf.sv
// ----------------------------------------------------------------------------
// hlfr_out_buf: result register with skid stage
// Holds the result on offer and one more, so the input side can still take
// a byte while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfr_out_buf
  import hlfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_res,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  // Refill the output register from the skid stage first, then from a push.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
        if (push) begin
          skid_nxt       = push_res;
          skid_valid_nxt = 1'b1;
        end
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_res;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end else begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end
    end
  end

  // Valid flags are cleared by reset; the payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

FILE: design/header_length_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// header_length_frame_receiver_top: two byte header, length prefixed deframer
// Hunts for the header, follows the frame by its length byte and passes on
// each frame byte with its position, the last-byte mark and the message id
// class.
//
//   Port group   Direction  Handshake        Contents
//   in_*         in         valid / ready    one received byte
//   out_*        out        valid / ready    frame byte, position, flags
//   cfg_*        in         write enable     header bytes and message ids
//
// Each result is registered before it shows on out_*; a new byte is
// accepted every cycle while in_ready is high. The result register plus
// a one entry skid stage decide in_ready: it drops only when both hold
// results that the consumer has not taken. Synchronous reset puts the
// parser back to hunting, clears the parser state, the configuration
// registers and the result valid flags; the result payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_frame_receiver_top
  import hlfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [ByteW-1:0]   in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ByteW-1:0]        out_frame_byte,
  output logic [ByteW-1:0]        out_byte_pos,
  output logic                    out_frame_last,
  output logic                    out_length_error,
  output logic [ByteW-1:0]        out_msg_id,
  output logic                    out_is_cmd_result,
  output logic                    out_is_data_msg
);

  cfg_t    cfg_r;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Configuration registers; index seven is not a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_FIRST:     cfg_r.header_first     <= cfg_wdata;
        REG_HEADER_SECOND:    cfg_r.header_second    <= cfg_wdata;
        REG_ID_RETURN_OK:     cfg_r.id_return_ok     <= cfg_wdata;
        REG_ID_RETURN_NG:     cfg_r.id_return_ng     <= cfg_wdata;
        REG_ID_RESEND_RESULT: cfg_r.id_resend_result <= cfg_wdata;
        REG_ID_DATA_ACK:      cfg_r.id_data_ack      <= cfg_wdata;
        REG_ID_DATA_NOACK:    cfg_r.id_data_noack    <= cfg_wdata;
        default:              cfg_r <= cfg_r;
      endcase
    end
  end

  // A request is taken whenever the output buffer has room.
  assign step = in_valid && in_ready;

  hlfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (step),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  hlfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_res  (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result fields to ports.
  assign out_frame_byte    = out_res.frame_byte;
  assign out_byte_pos      = out_res.byte_pos;
  assign out_frame_last    = out_res.frame_last;
  assign out_length_error  = out_res.length_error;
  assign out_msg_id        = out_res.msg_id;
  assign out_is_cmd_result = out_res.is_cmd_result;
  assign out_is_data_msg   = out_res.is_data_msg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for header_length_frame_receiver_top
// Streams received bytes through the valid/ready input. A behavioral parser
// inside the bench tracks the header hunt, the length byte and the message
// id, and predicts every result. Each result is compared field by field
// under several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hlfr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned MAX_FRAME_LEN = 255;

  // Index past the end of the register list; writes to it are dropped.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [ByteW-1:0]   in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [ByteW-1:0]   out_frame_byte;
  logic [ByteW-1:0]   out_byte_pos;
  logic               out_frame_last;
  logic               out_length_error;
  logic [ByteW-1:0]   out_msg_id;
  logic               out_is_cmd_result;
  logic               out_is_data_msg;

  // Shadow copy of the registers and of the parser state.
  cfg_t             regs;
  logic [ByteW-1:0] parse_pos;
  logic [ByteW-1:0] frame_len;
  logic [ByteW-1:0] held_id;

  // Results still owed by the block, oldest first.
  result_t awaited_results[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned bytes_framed;
  int unsigned results_checked;
  int unsigned frames_done;
  int unsigned length_errors;
  int unsigned errors;

  header_length_frame_receiver_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_byte_pos     (out_byte_pos),
    .out_frame_last   (out_frame_last),
    .out_length_error (out_length_error),
    .out_msg_id       (out_msg_id),
    .out_is_cmd_result(out_is_cmd_result),
    .out_is_data_msg  (out_is_data_msg)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run the received byte through the shadow parser and queue its result.
  function automatic void parse_rx_byte(input logic [ByteW-1:0] rx);
    result_t r;
    r            = '0;
    r.frame_byte = rx;
    r.byte_pos   = parse_pos;
    if (parse_pos == POS_HUNT) begin
      if (rx != regs.header_first) return;
      parse_pos = POS_HEADER2;
    end else if (parse_pos == POS_HEADER2) begin
      // A wrong second header byte is dropped, not retried as a first one.
      if (rx != regs.header_second) begin
        parse_pos = POS_HUNT;
        return;
      end
      parse_pos = POS_LENGTH;
    end else if (parse_pos == POS_LENGTH) begin
      if (rx < MIN_FRAME_LEN) begin
        r.length_error = 1'b1;
        parse_pos      = POS_HUNT;
      end else begin
        frame_len = rx;
        parse_pos = POS_MSG_ID;
      end
    end else begin
      if (parse_pos == POS_MSG_ID) held_id = rx;
      if ({1'b0, parse_pos} + 9'd1 >= {1'b0, frame_len}) begin
        r.frame_last    = 1'b1;
        r.msg_id        = held_id;
        r.is_cmd_result = (held_id == regs.id_return_ok) ||
                          (held_id == regs.id_return_ng) ||
                          (held_id == regs.id_resend_result);
        r.is_data_msg   = (held_id == regs.id_data_ack) ||
                          (held_id == regs.id_data_noack);
        parse_pos       = POS_HUNT;
      end else begin
        parse_pos = parse_pos + 8'd1;
      end
    end
    awaited_results.push_back(r);
    bytes_framed++;
  endfunction

  task automatic compare_field(input string name, input logic [ByteW-1:0] want,
                               input logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      $error("result with nothing awaited: frame_byte 0x%02h byte_pos %0d",
             out_frame_byte, out_byte_pos);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    results_checked++;
    compare_field("frame_byte", want.frame_byte, out_frame_byte);
    compare_field("byte_pos", want.byte_pos, out_byte_pos);
    compare_field("frame_last", 8'(want.frame_last), 8'(out_frame_last));
    compare_field("length_error", 8'(want.length_error), 8'(out_length_error));
    compare_field("msg_id", want.msg_id, out_msg_id);
    compare_field("is_cmd_result", 8'(want.is_cmd_result), 8'(out_is_cmd_result));
    compare_field("is_data_msg", 8'(want.is_data_msg), 8'(out_is_data_msg));
    if (want.frame_last) frames_done++;
    if (want.length_error) length_errors++;
  endtask

  // Predict on every accepted request, then check every delivered result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (out_valid && out_ready) check_result();
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one byte; valid stays high after acceptance until the next gap.
  task automatic send_byte(input logic [ByteW-1:0] rx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until the block has delivered everything.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Write all registers, plus one write to an unused index that must be ignored.
  task automatic load_config(input cfg_t c);
    cfg_we <= 1'b1;
    write_reg(REG_HEADER_FIRST, c.header_first);
    write_reg(REG_HEADER_SECOND, c.header_second);
    write_reg(REG_ID_RETURN_OK, c.id_return_ok);
    write_reg(REG_ID_RETURN_NG, c.id_return_ng);
    write_reg(REG_ID_RESEND_RESULT, c.id_resend_result);
    write_reg(REG_ID_DATA_ACK, c.id_data_ack);
    write_reg(REG_ID_DATA_NOACK, c.id_data_noack);
    write_reg(REG_UNUSED, 8'($urandom_range(255)));
    cfg_we <= 1'b0;
    regs = c;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.header_first     = 8'($urandom_range(255));
    c.header_second    = 8'($urandom_range(255));
    c.id_return_ok     = 8'($urandom_range(255));
    c.id_return_ng     = 8'($urandom_range(255));
    c.id_resend_result = 8'($urandom_range(255));
    c.id_data_ack      = 8'($urandom_range(255));
    c.id_data_noack    = 8'($urandom_range(255));
    return c;
  endfunction

  // One well-formed frame under the current headers, with random payload.
  task automatic send_frame(input int unsigned len, input logic [ByteW-1:0] id_byte);
    send_byte(regs.header_first);
    send_byte(regs.header_second);
    send_byte(8'(len));
    send_byte(id_byte);
    repeat (len - MIN_FRAME_LEN) send_byte(8'($urandom_range(255)));
  endtask

  // Mostly good frames; the rest is line noise, bad headers and short lengths.
  task automatic send_random_sequence();
    int unsigned      pick;
    int unsigned      len;
    logic [ByteW-1:0] id_byte;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 13) begin
      send_byte(regs.header_first);
      send_byte(regs.header_second ^ 8'($urandom_range(255, 1)));
    end else if (pick < 18) begin
      send_byte(regs.header_first);
      send_byte(regs.header_second);
      send_byte(8'($urandom_range(MIN_FRAME_LEN - 1)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 1) len = MAX_FRAME_LEN;
      else if (pick < 15) len = $urandom_range(40, 13);
      else len = $urandom_range(12, MIN_FRAME_LEN);
      case ($urandom_range(6))
        0:       id_byte = regs.id_return_ok;
        1:       id_byte = regs.id_return_ng;
        2:       id_byte = regs.id_resend_result;
        3:       id_byte = regs.id_data_ack;
        4:       id_byte = regs.id_data_noack;
        default: id_byte = 8'($urandom_range(255));
      endcase
      send_frame(len, id_byte);
    end
  endtask

  // Keep sending until the given number of framed bytes has been requested.
  task automatic run_stream(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_framed + count;
    while (bytes_framed < stop_at) send_random_sequence();
    settle();
  endtask

  // Registers as left by reset: both header bytes and all ids are zero.
  task automatic test_default_registers();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_stream(120);
  endtask

  // Hand-picked bytes for each parser corner.
  task automatic test_directed_cases();
    load_config('{header_first: 8'hA5, header_second: 8'h5A, id_return_ok: 8'h01,
                  id_return_ng: 8'h02, id_resend_result: 8'h03, id_data_ack: 8'h10,
                  id_data_noack: 8'h11});
    // Noise while hunting.
    send_byte(8'h00);
    // Wrong second header byte, at the top of the byte range.
    send_byte(8'hA5);
    send_byte(8'hFF);
    // A repeated first header byte is not taken as a new start, so the
    // following second header byte is ignored too.
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    // Lengths below the minimum frame are flagged and dropped.
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(MIN_FRAME_LEN - 8'd1);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    // Shortest frame: the message id is also the last byte.
    send_frame(MIN_FRAME_LEN, regs.id_return_ok);
    send_frame(MIN_FRAME_LEN + 1, regs.id_data_ack);
    settle();
  endtask

  task automatic test_clean_stream();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    load_config(random_config());
    run_stream(260);
  endtask

  // Extreme register values while the sender leaves gaps.
  task automatic test_sender_gaps();
    sender_idle_pct    = 49;
    receiver_stall_pct = 0;
    load_config('{header_first: 8'hFF, header_second: 8'h00, id_return_ok: 8'h00,
                  id_return_ng: 8'hFF, id_resend_result: 8'h80, id_data_ack: 8'h7F,
                  id_data_noack: 8'h01});
    run_stream(260);
  endtask

  // Includes one frame of the largest length under back-pressure.
  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 49;
    load_config(random_config());
    send_frame(MAX_FRAME_LEN, regs.id_resend_result);
    run_stream(260);
  endtask

  // All ids equal, so a matching id counts as both a command result and data.
  task automatic test_mixed_idling();
    cfg_t c;
    logic [ByteW-1:0] shared_id;
    sender_idle_pct    = 21;
    receiver_stall_pct = 21;
    c                  = random_config();
    shared_id          = 8'($urandom_range(255));
    c.id_return_ok     = shared_id;
    c.id_return_ng     = shared_id;
    c.id_resend_result = shared_id;
    c.id_data_ack      = shared_id;
    c.id_data_noack    = shared_id;
    load_config(c);
    run_stream(260);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_HEADER_FIRST;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_rx_byte         = '0;
    out_ready          = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    regs               = '0;
    parse_pos          = POS_HUNT;
    frame_len          = '0;
    held_id            = '0;
    cycle_count        = 0;
    bytes_sent         = 0;
    bytes_framed       = 0;
    results_checked    = 0;
    frames_done        = 0;
    length_errors      = 0;
    errors             = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_default_registers();
    test_directed_cases();
    test_clean_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    $display("Sent %0d bytes and checked %0d results: %0d complete frames, %0d short lengths.",
             bytes_sent, results_checked, frames_done, length_errors);
    $display("Ran six register settings with gaps and stalls on both channels.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/hlfr_pkg.sv
design/hlfr_parser.sv
design/hlfr_out_buf.sv
design/header_length_frame_receiver_top.sv
bench/testbench.sv
